/* sv/mrmd_pkg.sv */
// ----------------------------------------------------------------------------
// mrmd_pkg
// Shared widths, queue depth and the row summary record for the masked row
// mean and deviation block.
// ----------------------------------------------------------------------------
package mrmd_pkg;

    localparam int SMP_W           = 24;  // Q12.12 sample
    localparam int MSK_W           = 16;  // mask value and threshold
    localparam int OUT_CNT_W       = 11;  // reported used count
    localparam int MAX_COLUMNS_DEF = 1024;

    // Row sums are sized for the largest supported row of 4096 samples
    localparam int CNT_W   = 13;
    localparam int SUM_W   = SMP_W + CNT_W;          // signed sum
    localparam int SQ_W    = 2 * SMP_W - 1 + CNT_W;  // sum of squares
    localparam int DSQ_W   = 2 * SMP_W + 1 + CNT_W;  // sum of squared differences
    localparam int DIV_W   = DSQ_W;                  // shared divider dividend
    localparam int SQ_IN_W = DIV_W + (DIV_W % 2);    // root input, even width
    localparam int RT_W    = SQ_IN_W / 2;            // root width

    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Row summary handed from the accumulator to the result sequencer
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sqsum;
        logic [DSQ_W-1:0]        dsum;
    } row_rec_t;

endpackage

/* sv/mrmd_front.sv */
// ----------------------------------------------------------------------------
// mrmd_front
// Sample intake: mask test, base capture and a three stage accumulator that
// folds a sample per cycle when in_stall is low into row sums, queued per row.
// ----------------------------------------------------------------------------
module mrmd_front
    import mrmd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic signed [MSK_W-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [SMP_W-1:0] sample_value,
    input  logic signed [MSK_W-1:0] mask_value,
    input  logic                    last_in_row,
    input  logic [QCNT_W-1:0]       q_count,
    output logic                    push,
    output row_rec_t                push_rec
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_COLUMNS);

    logic signed [MSK_W-1:0] thr_reg;
    logic                    started_reg;
    logic signed [SMP_W-1:0] base_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic                    v1_reg, used1_reg, addd1_reg, last1_reg;
    logic signed [SMP_W-1:0] x1_reg;
    logic signed [SMP_W:0]   d1_reg;
    logic [CNT_W-1:0]        cnt1_reg;

    logic                    v2_reg, used2_reg, addd2_reg, last2_reg;
    logic signed [SMP_W-1:0] x2_reg;
    logic [2*SMP_W-2:0]      xx2_reg;
    logic [2*SMP_W:0]        dd2_reg;
    logic [CNT_W-1:0]        cnt2_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [DSQ_W-1:0]        dsq_reg, dsq_next;

    logic                    accept, first, used;
    logic signed [SMP_W-1:0] base_eff;
    logic [CNT_W-1:0]        cnt_used;
    logic [QCNT_W:0]         pending;
    logic signed [2*SMP_W-1:0] xx_full;
    logic signed [2*SMP_W+1:0] dd_full;

    // Hold off input while every queue slot is spoken for
    assign pending  = {1'b0, q_count} + (QCNT_W+1)'(v1_reg & last1_reg)
                    + (QCNT_W+1)'(v2_reg & last2_reg);
    assign in_stall = (pending >= (QCNT_W+1)'(QDEPTH));
    assign accept   = in_valid & ~in_stall;

    // Classify the incoming sample
    assign first    = ~started_reg;
    assign base_eff = first ? sample_value : base_reg;
    assign used     = (mask_value >= thr_reg) && (cnt_reg < LIMIT);
    assign cnt_used = cnt_reg + CNT_W'(used);

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Row tracking and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            base_reg    <= '0;
            cnt_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (accept)
            begin
                base_reg    <= base_eff;
                started_reg <= ~last_in_row;
                cnt_reg     <= last_in_row ? '0 : cnt_used;
            end
        end
    end

    // Stage one: sample and difference from the base
    always_ff @(posedge clk)
    begin
        x1_reg    <= sample_value;
        d1_reg    <= {sample_value[SMP_W-1], sample_value} - {base_eff[SMP_W-1], base_eff};
        used1_reg <= used;
        addd1_reg <= used & ~first;
        last1_reg <= last_in_row;
        cnt1_reg  <= cnt_used;
    end

    // Stage two: squares
    assign xx_full = x1_reg * x1_reg;
    assign dd_full = d1_reg * d1_reg;

    always_ff @(posedge clk)
    begin
        x2_reg    <= x1_reg;
        xx2_reg   <= xx_full[2*SMP_W-2:0];
        dd2_reg   <= dd_full[2*SMP_W:0];
        used2_reg <= used1_reg;
        addd2_reg <= addd1_reg;
        last2_reg <= last1_reg;
        cnt2_reg  <= cnt1_reg;
    end

    // Stage three: accumulate, hand the row on at its last sample
    always_comb
    begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        dsq_next = dsq_reg;
        if (used2_reg)
        begin
            sum_next = sum_reg + {{(SUM_W-SMP_W){x2_reg[SMP_W-1]}}, x2_reg};
            sq_next  = sq_reg + SQ_W'(xx2_reg);
        end
        if (addd2_reg)
        begin
            dsq_next = dsq_reg + DSQ_W'(dd2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
            dsq_reg <= '0;
        end
        else if (v2_reg)
        begin
            sum_reg <= last2_reg ? '0 : sum_next;
            sq_reg  <= last2_reg ? '0 : sq_next;
            dsq_reg <= last2_reg ? '0 : dsq_next;
        end
    end

    assign push           = v2_reg & last2_reg;
    assign push_rec.count = cnt2_reg;
    assign push_rec.sum   = sum_next;
    assign push_rec.sqsum = sq_next;
    assign push_rec.dsum  = dsq_next;

endmodule

/* sv/mrmd_queue.sv */
// ----------------------------------------------------------------------------
// mrmd_queue
// Short queue of row summaries between the accumulator and the sequencer.
// ----------------------------------------------------------------------------
module mrmd_queue
    import mrmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  row_rec_t          push_rec,
    input  logic              pop,
    output row_rec_t          head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(QDEPTH);

    row_rec_t            mem [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

/* sv/mrmd_div.sv */
// ----------------------------------------------------------------------------
// mrmd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrmd_div
    import mrmd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot,
    output logic [CNT_W-1:0] rem
);

    localparam int IT_W = $clog2(DIV_W);

    logic             busy_reg, done_reg;
    logic [IT_W-1:0]  it_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg, div_reg;
    logic [CNT_W:0]   shifted;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, div_reg});

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == IT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? CNT_W'(shifted - {1'b0, div_reg}) : shifted[CNT_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* sv/mrmd_sqrt.sv */
// ----------------------------------------------------------------------------
// mrmd_sqrt
// Floored integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module mrmd_sqrt
    import mrmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] radicand,
    output logic               done,
    output logic [RT_W-1:0]    root
);

    localparam int IT_W = $clog2(RT_W);

    logic               busy_reg, done_reg;
    logic [IT_W-1:0]    it_reg;
    logic [SQ_IN_W-1:0] val_reg;
    logic [RT_W-1:0]    root_reg;
    logic [RT_W+1:0]    rem_reg;
    logic [RT_W+3:0]    shifted, trial;
    logic               ge;

    assign shifted = {rem_reg, val_reg[SQ_IN_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = (shifted >= trial);

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == IT_W'(RT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Bring down two bits, try the next root bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[SQ_IN_W-3:0], 2'b00};
            root_reg <= {root_reg[RT_W-2:0], ge};
            rem_reg  <= ge ? (RT_W+2)'(shifted - trial) : shifted[RT_W+1:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* sv/mrmd_back.sv */
// ----------------------------------------------------------------------------
// mrmd_back
// Result sequencer: works one row summary at a time through the shared
// divider and root unit, then holds the result in the output register.
// ----------------------------------------------------------------------------
module mrmd_back
    import mrmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  row_rec_t                 head,
    input  logic                     q_empty,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SMP_W-1:0]  row_mean,
    output logic [SMP_W-1:0]         row_std_dev,
    output logic [SMP_W-1:0]         base_rms_dev,
    output logic [OUT_CNT_W-1:0]     used_count
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LOAD     = 4'd1;
    localparam logic [3:0] ST_DIV_MEAN = 4'd2;
    localparam logic [3:0] ST_MUL_A    = 4'd3;
    localparam logic [3:0] ST_MUL_B    = 4'd4;
    localparam logic [3:0] ST_SUB      = 4'd5;
    localparam logic [3:0] ST_DIV_VAR  = 4'd6;
    localparam logic [3:0] ST_TERM     = 4'd7;
    localparam logic [3:0] ST_VAR      = 4'd8;
    localparam logic [3:0] ST_SQ_SD    = 4'd9;
    localparam logic [3:0] ST_DIV_RMS  = 4'd10;
    localparam logic [3:0] ST_SQ_RMS   = 4'd11;
    localparam logic [3:0] ST_EMIT     = 4'd12;

    localparam int Q_W = SMP_W + 1;
    localparam int A_W = 2 * Q_W + CNT_W + 2;

    function automatic logic [SMP_W-1:0] sat24(input logic [RT_W-1:0] v);
        if (v > RT_W'({SMP_W{1'b1}}))
        begin
            return {SMP_W{1'b1}};
        end
        return v[SMP_W-1:0];
    endfunction

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg;

    row_rec_t                rec_reg;
    logic signed [SMP_W-1:0] mean_reg;
    logic signed [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0]        r_reg;
    logic [2*Q_W-1:0]        pqq_reg;
    logic signed [Q_W+CNT_W:0] pqr_reg;
    logic [2*Q_W+CNT_W-1:0]  pnqq_reg;
    logic [DIV_W-1:0]        k_reg;
    logic [2*CNT_W-1:0]      nj_reg, rr_reg;
    logic [SMP_W-1:0]        sd_reg, rms_reg;

    logic signed [SMP_W-1:0] out_mean_reg;
    logic [SMP_W-1:0]        out_sd_reg, out_rms_reg;
    logic [OUT_CNT_W-1:0]    out_cnt_reg;

    logic                    div_start, div_done, sq_start, sq_done;
    logic [DIV_W-1:0]        div_a, div_q;
    logic [CNT_W-1:0]        div_b, div_r, n_m1;
    logic [SQ_IN_W-1:0]      sq_in;
    logic [RT_W-1:0]         sq_root;

    logic                    sum_neg, var_neg, var_pos, emit_go;
    logic [SUM_W-1:0]        abs_sum;
    logic signed [Q_W-1:0]   qs;
    logic signed [2*Q_W-1:0] qq_full;
    logic signed [A_W-1:0]   a_full;
    logic [DIV_W-1:0]        a_clamp, var_val;
    logic [CNT_W+OUT_CNT_W-1:0] n_wide;

    mrmd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    mrmd_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Arithmetic on the working row
    assign sum_neg = rec_reg.sum[SUM_W-1];
    assign abs_sum = sum_neg ? SUM_W'(-rec_reg.sum) : SUM_W'(rec_reg.sum);
    assign n_m1    = rec_reg.count - 1'b1;
    assign qs      = sum_neg ? -$signed(div_q[Q_W-1:0]) : $signed(div_q[Q_W-1:0]);
    assign qq_full = q_reg * q_reg;
    assign a_full  = $signed({{(A_W-SQ_W){1'b0}}, rec_reg.sqsum})
                   - $signed({{(A_W-2*Q_W-CNT_W){1'b0}}, pnqq_reg})
                   - $signed({{(A_W-Q_W-CNT_W-2){pqr_reg[Q_W+CNT_W]}}, pqr_reg, 1'b0});
    assign a_clamp = a_full[A_W-1] ? '0 : DIV_W'(a_full[A_W-2:0]);
    assign var_neg = (nj_reg < rr_reg);
    assign var_val = k_reg - DIV_W'(var_neg);
    assign var_pos = (k_reg > DIV_W'(var_neg));
    assign emit_go = ~out_valid_reg | ~out_stall;
    assign n_wide  = (CNT_W+OUT_CNT_W)'(rec_reg.count);

    // Next state and unit starts
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_a      = DIV_W'(abs_sum);
        div_b      = rec_reg.count;
        sq_start   = 1'b0;
        sq_in      = SQ_IN_W'(var_val);
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (rec_reg.count == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                if (div_done)
                begin
                    state_next = (rec_reg.count == CNT_W'(1)) ? ST_EMIT : ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                div_start  = 1'b1;
                div_a      = a_clamp;
                div_b      = n_m1;
                state_next = ST_DIV_VAR;
            end
            ST_DIV_VAR:
            begin
                if (div_done)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                if (var_pos)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_SQ_SD;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = rec_reg.dsum;
                    div_b      = n_m1;
                    state_next = ST_DIV_RMS;
                end
            end
            ST_SQ_SD:
            begin
                if (sq_done)
                begin
                    div_start  = 1'b1;
                    div_a      = rec_reg.dsum;
                    div_b      = n_m1;
                    state_next = ST_DIV_RMS;
                end
            end
            ST_DIV_RMS:
            begin
                if (div_done)
                begin
                    sq_start   = 1'b1;
                    sq_in      = SQ_IN_W'(div_q);
                    state_next = ST_SQ_RMS;
                end
            end
            ST_SQ_RMS:
            begin
                if (sq_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    rec_reg  <= head;
                    mean_reg <= '0;
                    sd_reg   <= '0;
                    rms_reg  <= '0;
                end
            end
            ST_DIV_MEAN:
            begin
                if (div_done)
                begin
                    mean_reg <= qs[SMP_W-1:0];
                    if (sum_neg && div_r != '0)
                    begin
                        q_reg <= qs - 1'b1;
                        r_reg <= rec_reg.count - div_r;
                    end
                    else
                    begin
                        q_reg <= qs;
                        r_reg <= div_r;
                    end
                end
            end
            ST_MUL_A:
            begin
                pqq_reg <= qq_full;
                pqr_reg <= q_reg * $signed({1'b0, r_reg});
            end
            ST_MUL_B:
            begin
                pnqq_reg <= pqq_reg * rec_reg.count;
            end
            ST_DIV_VAR:
            begin
                if (div_done)
                begin
                    k_reg  <= div_q;
                    nj_reg <= (2*CNT_W)'(div_r);
                end
            end
            ST_TERM:
            begin
                nj_reg <= nj_reg[CNT_W-1:0] * rec_reg.count;
                rr_reg <= r_reg * r_reg;
            end
            ST_SQ_SD:
            begin
                if (sq_done)
                begin
                    sd_reg <= sat24(sq_root);
                end
            end
            ST_SQ_RMS:
            begin
                if (sq_done)
                begin
                    rms_reg <= sat24(sq_root);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_mean_reg <= mean_reg;
            out_sd_reg   <= sd_reg;
            out_rms_reg  <= rms_reg;
            out_cnt_reg  <= (n_wide > (CNT_W+OUT_CNT_W)'({OUT_CNT_W{1'b1}}))
                          ? {OUT_CNT_W{1'b1}} : n_wide[OUT_CNT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_mean     = out_mean_reg;
    assign row_std_dev  = out_sd_reg;
    assign base_rms_dev = out_rms_reg;
    assign used_count   = out_cnt_reg;

endmodule

/* sv/masked_row_mean_and_deviation.sv */
// ----------------------------------------------------------------------------
// masked_row_mean_and_deviation
// Per-row masked mean, sample standard deviation and RMS deviation from the
// first column of a stream of Q12.12 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while in_stall is low; each row's last
// sample closes the row and its sums go into a four-entry summary queue. A
// sequencer then works each row through a shared bit-serial divider (62
// steps a pass, up to three passes) and a bit-serial square root (31 steps
// a pass, up to two passes), so short rows can, once the queue fills, see
// in_stall held high until a slot frees. One result per row appears on the
// output register, which keeps its value while out_valid and out_stall are
// both high.
// mask_threshold is written through cfg_valid/cfg_data and is always ready.
module masked_row_mean_and_deviation
    import mrmd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [MSK_W-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [SMP_W-1:0]  sample_value,
    input  logic signed [MSK_W-1:0]  mask_value,
    input  logic                     last_in_row,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SMP_W-1:0]  row_mean,
    output logic [SMP_W-1:0]         row_std_dev,
    output logic [SMP_W-1:0]         base_rms_dev,
    output logic [OUT_CNT_W-1:0]     used_count
);

    logic              push, pop, q_empty;
    row_rec_t          push_rec, head;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    mrmd_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .mask_value   (mask_value),
        .last_in_row  (last_in_row),
        .q_count      (q_count),
        .push         (push),
        .push_rec     (push_rec)
    );

    mrmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .count    (q_count)
    );

    mrmd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_mean     (row_mean),
        .row_std_dev  (row_std_dev),
        .base_rms_dev (base_rms_dev),
        .used_count   (used_count)
    );

endmodule

/* sv/mrmd_checker.sv */
// ----------------------------------------------------------------------------
// mrmd_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mrmd_checker
    import mrmd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [SMP_W-1:0] row_mean,
    input logic [SMP_W-1:0]        row_std_dev,
    input logic [SMP_W-1:0]        base_rms_dev,
    input logic [OUT_CNT_W-1:0]    used_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_mean)
            && $stable(row_std_dev) && $stable(base_rms_dev) && $stable(used_count))
        else $error("stalled result changed");

    // Fewer than two used samples give no deviation
    a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_count < OUT_CNT_W'(2) |-> row_std_dev == '0 && base_rms_dev == '0)
        else $error("deviation reported for a row with fewer than two samples");

    // An empty row has a zero mean
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_count == '0 |-> row_mean == '0)
        else $error("mean reported for an empty row");

endmodule

bind masked_row_mean_and_deviation mrmd_checker u_mrmd_checker (.*);
